FILE: hw/rtl/sha256_pkg.sv
`timescale 1ns / 1ps

package sha256_pkg;

  typedef enum logic {
    OP_ABSORB = 1'b0,
    OP_FINISH = 1'b1
  } op_e;

  typedef struct packed {
    op_e        op;
    logic [7:0] data;
  } item_t;

  // Commands from the sequencer to the compression engine.
  typedef struct packed {
    logic        word_vld;
    logic [31:0] word;
    logic        start;
    logic        chain_init;
  } core_cmd_t;

  typedef struct packed {
    logic busy;
    logic done;
  } core_stat_t;

  // Initial hash values, entry 0 in the low bits.
  localparam logic [7:0][31:0] SHA_IV = {
    32'h5be0cd19, 32'h1f83d9ab, 32'h9b05688c, 32'h510e527f,
    32'ha54ff53a, 32'h3c6ef372, 32'hbb67ae85, 32'h6a09e667
  };

  localparam logic [63:0] BLOCK_BITS = 64'd512;
  localparam logic [5:0]  LEN_POS    = 6'd56;
  localparam logic [7:0]  PAD_BYTE   = 8'h80;

  function automatic logic [31:0] big0(input logic [31:0] x);
    big0 = {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
  endfunction

  function automatic logic [31:0] big1(input logic [31:0] x);
    big1 = {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
  endfunction

  function automatic logic [31:0] small0(input logic [31:0] x);
    small0 = {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
  endfunction

  function automatic logic [31:0] small1(input logic [31:0] x);
    small1 = {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'b0, x[31:10]};
  endfunction

  function automatic logic [31:0] choose(input logic [31:0] e, input logic [31:0] f,
                                         input logic [31:0] g);
    choose = (e & f) ^ (~e & g);
  endfunction

  function automatic logic [31:0] major(input logic [31:0] a, input logic [31:0] b,
                                        input logic [31:0] c);
    major = (a & b) ^ (a & c) ^ (b & c);
  endfunction

  function automatic logic [31:0] round_k(input logic [5:0] t);
    unique case (t)
      6'd0:  round_k = 32'h428a2f98;
      6'd1:  round_k = 32'h71374491;
      6'd2:  round_k = 32'hb5c0fbcf;
      6'd3:  round_k = 32'he9b5dba5;
      6'd4:  round_k = 32'h3956c25b;
      6'd5:  round_k = 32'h59f111f1;
      6'd6:  round_k = 32'h923f82a4;
      6'd7:  round_k = 32'hab1c5ed5;
      6'd8:  round_k = 32'hd807aa98;
      6'd9:  round_k = 32'h12835b01;
      6'd10: round_k = 32'h243185be;
      6'd11: round_k = 32'h550c7dc3;
      6'd12: round_k = 32'h72be5d74;
      6'd13: round_k = 32'h80deb1fe;
      6'd14: round_k = 32'h9bdc06a7;
      6'd15: round_k = 32'hc19bf174;
      6'd16: round_k = 32'he49b69c1;
      6'd17: round_k = 32'hefbe4786;
      6'd18: round_k = 32'h0fc19dc6;
      6'd19: round_k = 32'h240ca1cc;
      6'd20: round_k = 32'h2de92c6f;
      6'd21: round_k = 32'h4a7484aa;
      6'd22: round_k = 32'h5cb0a9dc;
      6'd23: round_k = 32'h76f988da;
      6'd24: round_k = 32'h983e5152;
      6'd25: round_k = 32'ha831c66d;
      6'd26: round_k = 32'hb00327c8;
      6'd27: round_k = 32'hbf597fc7;
      6'd28: round_k = 32'hc6e00bf3;
      6'd29: round_k = 32'hd5a79147;
      6'd30: round_k = 32'h06ca6351;
      6'd31: round_k = 32'h14292967;
      6'd32: round_k = 32'h27b70a85;
      6'd33: round_k = 32'h2e1b2138;
      6'd34: round_k = 32'h4d2c6dfc;
      6'd35: round_k = 32'h53380d13;
      6'd36: round_k = 32'h650a7354;
      6'd37: round_k = 32'h766a0abb;
      6'd38: round_k = 32'h81c2c92e;
      6'd39: round_k = 32'h92722c85;
      6'd40: round_k = 32'ha2bfe8a1;
      6'd41: round_k = 32'ha81a664b;
      6'd42: round_k = 32'hc24b8b70;
      6'd43: round_k = 32'hc76c51a3;
      6'd44: round_k = 32'hd192e819;
      6'd45: round_k = 32'hd6990624;
      6'd46: round_k = 32'hf40e3585;
      6'd47: round_k = 32'h106aa070;
      6'd48: round_k = 32'h19a4c116;
      6'd49: round_k = 32'h1e376c08;
      6'd50: round_k = 32'h2748774c;
      6'd51: round_k = 32'h34b0bcb5;
      6'd52: round_k = 32'h391c0cb3;
      6'd53: round_k = 32'h4ed8aa4a;
      6'd54: round_k = 32'h5b9cca4f;
      6'd55: round_k = 32'h682e6ff3;
      6'd56: round_k = 32'h748f82ee;
      6'd57: round_k = 32'h78a5636f;
      6'd58: round_k = 32'h84c87814;
      6'd59: round_k = 32'h8cc70208;
      6'd60: round_k = 32'h90befffa;
      6'd61: round_k = 32'ha4506ceb;
      6'd62: round_k = 32'hbef9a3f7;
      6'd63: round_k = 32'hc67178f2;
    endcase
  endfunction

endpackage

FILE: hw/rtl/sha256_front.sv
`timescale 1ns / 1ps

module sha256_front import sha256_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // [7:0] data_byte
  input  logic       s_axis_tuser,   // [0] kind
  output logic       q_valid_o,
  output item_t      q_item_o,
  input  logic       q_ready_i
);

  item_t       entry_q [2];
  logic        wr_ptr_q, wr_ptr_d;
  logic        rd_ptr_q, rd_ptr_d;
  logic [1:0]  cnt_q, cnt_d;
  logic        push, pop;
  item_t       item_in;

  always_comb begin
    item_in.op   = s_axis_tuser ? OP_FINISH : OP_ABSORB;
    item_in.data = s_axis_tdata;
  end

  assign s_axis_tready = (cnt_q != 2'd2);
  assign push          = s_axis_tvalid && s_axis_tready;
  assign q_valid_o     = (cnt_q != 2'd0);
  assign pop           = q_valid_o && q_ready_i;
  assign q_item_o      = entry_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop ? ~rd_ptr_q : rd_ptr_q;
    cnt_d    = cnt_q + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      entry_q[wr_ptr_q] <= item_in;
    end
  end

endmodule

FILE: hw/rtl/sha256_core.sv
`timescale 1ns / 1ps

module sha256_core import sha256_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  core_cmd_t         cmd_i,
  output core_stat_t        stat_o,
  output logic [7:0][31:0]  chain_o
);

  logic [7:0][31:0]  chain_q;
  logic [7:0][31:0]  v_q;
  logic [15:0][31:0] w_q;
  logic [5:0]        round_q;
  logic              busy_q;
  logic              add_q;

  logic [31:0] t1, t2, sched_new;

  always_comb begin
    t1 = v_q[7] + big1(v_q[4]) + choose(v_q[4], v_q[5], v_q[6]) + round_k(round_q) + w_q[0];
    t2 = big0(v_q[0]) + major(v_q[0], v_q[1], v_q[2]);
    sched_new = small1(w_q[14]) + w_q[9] + small0(w_q[1]) + w_q[0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q  <= 1'b0;
      add_q   <= 1'b0;
      round_q <= 6'd0;
      chain_q <= SHA_IV;
    end else begin
      add_q <= busy_q && (round_q == 6'd63);
      if (cmd_i.start) begin
        busy_q  <= 1'b1;
        round_q <= 6'd0;
      end else if (busy_q) begin
        round_q <= round_q + 6'd1;
        if (round_q == 6'd63) begin
          busy_q <= 1'b0;
        end
      end
      if (cmd_i.chain_init) begin
        chain_q <= SHA_IV;
      end else if (add_q) begin
        for (int i = 0; i < 8; i++) begin
          chain_q[i] <= chain_q[i] + v_q[i];
        end
      end
    end
  end

  // Working variables and the 16-word schedule window.
  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      v_q <= chain_q;
    end else if (busy_q) begin
      v_q[7] <= v_q[6];
      v_q[6] <= v_q[5];
      v_q[5] <= v_q[4];
      v_q[4] <= v_q[3] + t1;
      v_q[3] <= v_q[2];
      v_q[2] <= v_q[1];
      v_q[1] <= v_q[0];
      v_q[0] <= t1 + t2;
    end
    if (cmd_i.word_vld || busy_q) begin
      for (int i = 0; i < 15; i++) begin
        w_q[i] <= w_q[i+1];
      end
      w_q[15] <= busy_q ? sched_new : cmd_i.word;
    end
  end

  assign stat_o.busy = busy_q;
  assign stat_o.done = add_q;
  assign chain_o     = chain_q;

endmodule

FILE: hw/rtl/sha256_back.sv
`timescale 1ns / 1ps

module sha256_back import sha256_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              q_valid_i,
  input  item_t             q_item_i,
  output logic              q_ready_o,
  output core_cmd_t         cmd_o,
  input  core_stat_t        stat_i,
  input  logic [7:0][31:0]  chain_i,
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  output logic [31:0]       m_axis_tdata,   // [31:0] digest_word
  output logic [2:0]        m_axis_tuser,   // [2:0] word_index
  output logic              m_axis_tlast    // last_word
);

  localparam logic [1:0] ST_RUN  = 2'd0;
  localparam logic [1:0] ST_PAD  = 2'd1;
  localparam logic [1:0] ST_WAIT = 2'd2;
  localparam logic [1:0] ST_OUT  = 2'd3;

  logic [1:0]  state_q, state_d;
  logic [5:0]  fill_q, fill_d;
  logic [23:0] acc_q, acc_d;
  logic [63:0] bitlen_q, bitlen_d;
  logic [63:0] total_q, total_d;
  logic        pad_q, pad_d;
  logic        sent80_q, sent80_d;
  logic        lenblk_q, lenblk_d;
  logic        final_q, final_d;
  logic [2:0]  idx_q, idx_d;
  logic        m_valid_q, m_valid_d;
  logic [31:0] m_data_q, m_data_d;
  logic [2:0]  m_user_q, m_user_d;
  logic        m_last_q, m_last_d;

  logic        byte_vld;
  logic [7:0]  byte_val;
  logic [63:0] len_shift;

  // Length bytes go out most significant first at positions 56 to 63.
  assign len_shift = total_q >> {~fill_q[2:0], 3'b000};

  always_comb begin
    state_d   = state_q;
    fill_d    = fill_q;
    acc_d     = acc_q;
    bitlen_d  = bitlen_q;
    total_d   = total_q;
    pad_d     = pad_q;
    sent80_d  = sent80_q;
    lenblk_d  = lenblk_q;
    final_d   = final_q;
    idx_d     = idx_q;
    m_valid_d = m_valid_q;
    m_data_d  = m_data_q;
    m_user_d  = m_user_q;
    m_last_d  = m_last_q;
    byte_vld  = 1'b0;
    byte_val  = 8'h00;
    q_ready_o = 1'b0;
    cmd_o     = '0;

    if (m_axis_tready) begin
      m_valid_d = 1'b0;
    end

    unique case (state_q)
      ST_RUN: begin
        q_ready_o = 1'b1;
        if (q_valid_i) begin
          if (q_item_i.op == OP_ABSORB) begin
            byte_vld = 1'b1;
            byte_val = q_item_i.data;
          end else begin
            total_d  = bitlen_q + {55'b0, fill_q, 3'b000};
            pad_d    = 1'b1;
            sent80_d = 1'b0;
            lenblk_d = 1'b0;
            final_d  = 1'b0;
            state_d  = ST_PAD;
          end
        end
      end
      ST_PAD: begin
        byte_vld = 1'b1;
        if (!sent80_q) begin
          byte_val = PAD_BYTE;
          sent80_d = 1'b1;
          lenblk_d = (fill_q < LEN_POS);
        end else if (lenblk_q && (fill_q >= LEN_POS)) begin
          byte_val = len_shift[7:0];
        end
      end
      ST_WAIT: begin
        if (stat_i.done) begin
          if (final_q) begin
            idx_d   = 3'd0;
            state_d = ST_OUT;
          end else if (pad_q) begin
            state_d = ST_PAD;
          end else begin
            state_d = ST_RUN;
          end
        end
      end
      ST_OUT: begin
        if (!m_valid_q || m_axis_tready) begin
          m_valid_d = 1'b1;
          m_data_d  = chain_i[idx_q];
          m_user_d  = idx_q;
          m_last_d  = (idx_q == 3'd7);
          idx_d     = idx_q + 3'd1;
          if (idx_q == 3'd7) begin
            cmd_o.chain_init = 1'b1;
            bitlen_d = 64'd0;
            pad_d    = 1'b0;
            final_d  = 1'b0;
            state_d  = ST_RUN;
          end
        end
      end
    endcase

    // Common byte path: pack four bytes into a word, start a block when full.
    if (byte_vld) begin
      fill_d = fill_q + 6'd1;
      if (fill_q[1:0] == 2'b11) begin
        cmd_o.word_vld = 1'b1;
        cmd_o.word     = {acc_q, byte_val};
      end else begin
        acc_d = {acc_q[15:0], byte_val};
      end
      if (fill_q == 6'd63) begin
        cmd_o.start = 1'b1;
        state_d     = ST_WAIT;
        if (pad_q) begin
          // A block that held the length ends the message; otherwise the
          // next block carries it.
          final_d  = lenblk_q;
          lenblk_d = 1'b1;
        end else begin
          bitlen_d = bitlen_q + BLOCK_BITS;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_RUN;
      fill_q    <= 6'd0;
      bitlen_q  <= 64'd0;
      pad_q     <= 1'b0;
      sent80_q  <= 1'b0;
      lenblk_q  <= 1'b0;
      final_q   <= 1'b0;
      idx_q     <= 3'd0;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      fill_q    <= fill_d;
      bitlen_q  <= bitlen_d;
      pad_q     <= pad_d;
      sent80_q  <= sent80_d;
      lenblk_q  <= lenblk_d;
      final_q   <= final_d;
      idx_q     <= idx_d;
      m_valid_q <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q    <= acc_d;
    total_q  <= total_d;
    m_data_q <= m_data_d;
    m_user_q <= m_user_d;
    m_last_q <= m_last_d;
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;
  assign m_axis_tuser  = m_user_q;
  assign m_axis_tlast  = m_last_q;

endmodule

FILE: hw/rtl/sha256_byte_stream_hasher_top.sv
`timescale 1ns / 1ps

// SHA-256 hasher fed one message byte per input word (tuser low) and closed by
// a finish word (tuser high), which pads the message and returns the eight
// digest words, word 0 first, with tlast on word 7; the hasher is then ready
// for a new message. A two-entry input queue keeps taking words while the
// sequencer behind it is busy, until it is full. Every 64th data byte starts a
// block compression (64 rounds on a single round unit plus the chaining add),
// during which the sequencer takes no bytes. A finish pads the message byte by
// byte up to the end of the block (one or two blocks of padding), runs one
// compression per padded block, and hands out the digest words as the sink
// takes them.
module sha256_byte_stream_hasher_top import sha256_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
  input  logic        s_axis_tuser,   // [0] kind
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // [31:0] digest_word
  output logic [2:0]  m_axis_tuser,   // [2:0] word_index
  output logic        m_axis_tlast    // last_word
);

  logic             q_valid;
  logic             q_ready;
  item_t            q_item;
  core_cmd_t        core_cmd;
  core_stat_t       core_stat;
  logic [7:0][31:0] chain;

  sha256_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .q_valid_o     (q_valid),
    .q_item_o      (q_item),
    .q_ready_i     (q_ready)
  );

  sha256_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .q_valid_i     (q_valid),
    .q_item_i      (q_item),
    .q_ready_o     (q_ready),
    .cmd_o         (core_cmd),
    .stat_i        (core_stat),
    .chain_i       (chain),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  sha256_core u_core (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cmd_i   (core_cmd),
    .stat_o  (core_stat),
    .chain_o (chain)
  );

  a_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    core_cmd.start |-> !core_stat.busy)
    else $error("compression started while rounds are running");

  a_word_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    core_cmd.word_vld |-> !core_stat.busy)
    else $error("schedule word pushed while rounds are running");

  a_done_after_rounds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    core_stat.done |-> $past(core_stat.busy))
    else $error("chaining add without a preceding round");

  a_last_index: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tlast) |-> (m_axis_tuser == 3'd7))
    else $error("last digest word carries the wrong index");

endmodule

FILE: tb/tb_sha256_byte_stream_hasher_top.sv
`timescale 1ns / 1ps

module tb_sha256_byte_stream_hasher_top;
  import sha256_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int ITEM_TARGET = 270;
  localparam int DRAIN_CYCLES = 20;

  localparam logic [31:0] ROUND_K [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  localparam logic [31:0] START_HASH [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  // Message lengths around the padding and block boundaries.
  localparam int BOUNDARY_LENS [10] = '{0, 55, 56, 57, 63, 64, 65, 119, 120, 128};

  typedef struct packed {
    op_e          op;
    logic [7:0]   data;
    logic         known;
    logic [255:0] digest;
  } stim_row_t;

  localparam int NUM_ROWS = 10;
  localparam stim_row_t STIM_ROWS [NUM_ROWS] = '{
    // The empty message, with a data byte that must be ignored.
    '{OP_FINISH, 8'hff, 1'b1,
      256'he3b0c44298fc1c149afbf4c8996fb92427ae41e4649b934ca495991b7852b855},
    '{OP_ABSORB, 8'h61, 1'b0, 256'h0},
    '{OP_ABSORB, 8'h62, 1'b0, 256'h0},
    '{OP_ABSORB, 8'h63, 1'b0, 256'h0},
    '{OP_FINISH, 8'h00, 1'b1,
      256'hba7816bf8f01cfea414140de5dae2223b00361a396177a9cb410ff61f20015ad},
    '{OP_ABSORB, 8'h00, 1'b0, 256'h0},
    '{OP_ABSORB, 8'hff, 1'b0, 256'h0},
    '{OP_ABSORB, 8'h80, 1'b0, 256'h0},
    '{OP_ABSORB, 8'h7f, 1'b0, 256'h0},
    '{OP_FINISH, 8'h5a, 1'b0, 256'h0}
  };

  typedef struct packed {
    logic [31:0] word;
    logic [2:0]  index;
    logic        last;
  } digest_beat_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = 8'h00;
  logic        s_axis_tuser = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;
  logic [2:0]  m_axis_tuser;
  logic        m_axis_tlast;

  digest_beat_t digest_words_due[$];
  int           err_count = 0;
  int           cycle_count = 0;
  int           items_sent = 0;
  int           sink_hold = 0;
  bit           fast_src = 1'b0;
  bit           fast_sink = 1'b0;

  // Hash state kept alongside the block.
  logic [31:0] hash_words [8];
  logic [7:0]  msg_block [64];
  int          pending_bytes;
  logic [63:0] length_bits;

  sha256_byte_stream_hasher_top dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  always #5 clk_i = ~clk_i;

  function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  function automatic void hasher_clear();
    for (int i = 0; i < 8; i++) hash_words[i] = START_HASH[i];
    for (int i = 0; i < 64; i++) msg_block[i] = 8'h00;
    pending_bytes = 0;
    length_bits = 64'd0;
  endfunction

  function automatic void compress_block();
    logic [31:0] w [64];
    logic [31:0] a, b, c, d, e, f, g, h, t1, t2, s0, s1;
    for (int i = 0; i < 16; i++) begin
      w[i] = {msg_block[4*i], msg_block[4*i+1], msg_block[4*i+2], msg_block[4*i+3]};
    end
    for (int i = 16; i < 64; i++) begin
      s0 = rotr(w[i-15], 7) ^ rotr(w[i-15], 18) ^ (w[i-15] >> 3);
      s1 = rotr(w[i-2], 17) ^ rotr(w[i-2], 19) ^ (w[i-2] >> 10);
      w[i] = s1 + w[i-7] + s0 + w[i-16];
    end
    a = hash_words[0]; b = hash_words[1]; c = hash_words[2]; d = hash_words[3];
    e = hash_words[4]; f = hash_words[5]; g = hash_words[6]; h = hash_words[7];
    for (int i = 0; i < 64; i++) begin
      t1 = h + (rotr(e, 6) ^ rotr(e, 11) ^ rotr(e, 25)) + ((e & f) ^ (~e & g))
           + ROUND_K[i] + w[i];
      t2 = (rotr(a, 2) ^ rotr(a, 13) ^ rotr(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
      h = g; g = f; f = e; e = d + t1;
      d = c; c = b; b = a; a = t1 + t2;
    end
    hash_words[0] += a; hash_words[1] += b; hash_words[2] += c; hash_words[3] += d;
    hash_words[4] += e; hash_words[5] += f; hash_words[6] += g; hash_words[7] += h;
  endfunction

  function automatic void hasher_absorb(input logic [7:0] data);
    msg_block[pending_bytes] = data;
    pending_bytes++;
    if (pending_bytes == 64) begin
      compress_block();
      pending_bytes = 0;
      length_bits += 64'd512;
    end
  endfunction

  function automatic logic [255:0] hasher_finish();
    logic [63:0]  total;
    logic [255:0] digest;
    int           n;
    total = length_bits + 64'(pending_bytes * 8);
    n = pending_bytes;
    msg_block[n] = 8'h80;
    n++;
    // No room left for the length: pad out this block and use one more.
    if (n > 56) begin
      while (n < 64) begin
        msg_block[n] = 8'h00;
        n++;
      end
      compress_block();
      n = 0;
    end
    while (n < 56) begin
      msg_block[n] = 8'h00;
      n++;
    end
    for (int i = 0; i < 8; i++) msg_block[56+i] = total[63-8*i -: 8];
    compress_block();
    for (int i = 0; i < 8; i++) digest[255-32*i -: 32] = hash_words[i];
    hasher_clear();
    return digest;
  endfunction

  function automatic void push_digest(input logic [255:0] digest);
    digest_beat_t beat;
    for (int i = 0; i < 8; i++) begin
      beat.word = digest[255-32*i -: 32];
      beat.index = 3'(i);
      beat.last = (i == 7);
      digest_words_due.push_back(beat);
    end
  endfunction

  task automatic send_item(input op_e op, input logic [7:0] data, input logic known,
                           input logic [255:0] known_digest);
    int gap;
    logic [255:0] digest;
    gap = fast_src ? 0 : $urandom_range(0, 16);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= data;
    s_axis_tuser <= op;
    do @(posedge clk_i); while (!s_axis_tready);
    items_sent++;
    if (op == OP_ABSORB) begin
      hasher_absorb(data);
    end else begin
      digest = hasher_finish();
      push_digest(known ? known_digest : digest);
    end
  endtask

  task automatic wait_all_digests();
    while (digest_words_due.size() != 0) @(posedge clk_i);
  endtask

  task automatic check_word();
    digest_beat_t due;
    if (digest_words_due.size() == 0) begin
      $error("unexpected digest word 0x%08h (index %0d)", m_axis_tdata, m_axis_tuser);
      err_count++;
    end else begin
      due = digest_words_due.pop_front();
      if (m_axis_tdata !== due.word) begin
        $error("digest_word: expected 0x%08h, got 0x%08h", due.word, m_axis_tdata);
        err_count++;
      end
      if (m_axis_tuser !== due.index) begin
        $error("word_index: expected %0d, got %0d", due.index, m_axis_tuser);
        err_count++;
      end
      if (m_axis_tlast !== due.last) begin
        $error("last_word: expected %0b, got %0b", due.last, m_axis_tlast);
        err_count++;
      end
    end
  endtask

  // Result side: a random stall is drawn after each word and spent while a
  // word is offered.
  always @(posedge clk_i) begin
    if (m_axis_tvalid && m_axis_tready) begin
      check_word();
      sink_hold = fast_sink ? 0 : $urandom_range(0, 16);
    end
    if (sink_hold > 0) begin
      m_axis_tready <= 1'b0;
      if (m_axis_tvalid) sink_hold--;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("** sha256_byte_stream_hasher_top: FAILED **");
      $finish;
    end
  end

  initial begin
    int msg_len;
    int msg_count;
    hasher_clear();
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int r = 0; r < NUM_ROWS; r++) begin
      send_item(STIM_ROWS[r].op, STIM_ROWS[r].data, STIM_ROWS[r].known,
                STIM_ROWS[r].digest);
    end
    s_axis_tvalid <= 1'b0;
    wait_all_digests();

    msg_count = 0;
    while (items_sent < ITEM_TARGET) begin
      if ($urandom_range(0, 2) == 0) msg_len = BOUNDARY_LENS[$urandom_range(0, 9)];
      else msg_len = $urandom_range(0, 24);
      // The last message is cut short so that the run ends exactly at the target.
      if (items_sent + msg_len + 1 > ITEM_TARGET) msg_len = ITEM_TARGET - items_sent - 1;
      fast_src = ($urandom_range(0, 3) == 0);
      fast_sink = ($urandom_range(0, 3) == 0);
      for (int j = 0; j < msg_len; j++) begin
        send_item(OP_ABSORB, 8'($urandom_range(0, 255)), 1'b0, 256'h0);
      end
      send_item(OP_FINISH, 8'($urandom_range(0, 255)), 1'b0, 256'h0);
      msg_count++;
      if (msg_count == 4) begin
        s_axis_tvalid <= 1'b0;
        wait_all_digests();
      end
    end
    s_axis_tvalid <= 1'b0;

    wait_all_digests();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (err_count == 0) begin
      $display("** sha256_byte_stream_hasher_top: PASSED **");
    end else begin
      $display("** sha256_byte_stream_hasher_top: FAILED **");
    end
    $finish;
  end

endmodule
